// File: hw/rtl/tac_pkg.sv
package tac_pkg;

	// Classes of sample that bypass the arithmetic result.
	typedef enum logic [1:0] {
		KIND_NORMAL,
		KIND_ZERO,
		KIND_POS90,
		KIND_NEG90
	} kind_t;

	// Control that travels alongside each request through the pipeline.
	typedef struct packed {
		logic  valid;
		kind_t kind;
	} tag_t;

	localparam tag_t TAG_IDLE = '{valid: 1'b0, kind: KIND_NORMAL};

	// Square root: 64-bit radicand, 32-bit root, one bit per stage.
	localparam int unsigned SQ_OP_W     = 64;
	localparam int unsigned ROOT_W      = 32;
	localparam int unsigned ISQRT_STEPS = 32;

	// CORDIC vector width and angle accumulator width.
	localparam int unsigned CX_W      = 36;
	localparam int unsigned ACC_W     = 32;
	localparam int unsigned TABLE_LEN = 32;

	// Output limit in centidegrees.
	localparam int unsigned TILT_W   = 15;
	localparam logic signed [TILT_W-1:0] TILT_MAX = 15'sd9000;

	// Fixed part of the request-to-result latency; add the CORDIC stage count.
	localparam int unsigned LATENCY_BASE = 36;

	// atan(2^-i) in centidegrees times 65536, rounded to nearest.
	localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd294912000, 32'sd174096719, 32'sd91987925, 32'sd46694507,
		32'sd23437865,  32'sd11730358,  32'sd5866610,  32'sd2933484,
		32'sd1466764,   32'sd733385,    32'sd366693,   32'sd183346,
		32'sd91673,     32'sd45837,     32'sd22918,    32'sd11459,
		32'sd5730,      32'sd2865,      32'sd1432,     32'sd716,
		32'sd358,       32'sd179,       32'sd90,       32'sd45,
		32'sd22,        32'sd11,        32'sd6,        32'sd3,
		32'sd1,         32'sd1,         32'sd0,        32'sd0
	};

endpackage

// File: hw/rtl/accel_tilt_angle_core.sv
// An accepted request reaches its done strobe through the input stages, 32 square-root
// stages, CORDIC_STAGES CORDIC stages (default 16) and the output stages.
// Throughput: one request per cycle; busy stays low and start is taken every cycle.
// The receiver cannot stall, so each result shows for exactly one cycle.
// Reset (arst_n low, asynchronous) clears all valid bits; no request is in flight after it.
module accel_tilt_angle_core #(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [15:0]  accel_x,
	input  logic signed [15:0]  accel_y,
	input  logic signed [15:0]  accel_z,
	output logic                done,
	output logic signed [14:0]  tilt_centideg
);
	import tac_pkg::*;

	// The pipeline never holds off a request.
	assign busy = 1'b0;

	// Sort out the samples that skip the arithmetic.
	kind_t kind_in;
	always_comb begin
		if (accel_x == 16'sd0) begin
			kind_in = KIND_ZERO;
		end else if (accel_y == 16'sd0 && accel_z == 16'sd0) begin
			kind_in = accel_x[15] ? KIND_NEG90 : KIND_POS90;
		end else begin
			kind_in = KIND_NORMAL;
		end
	end

	// Stage 1: square the Y and Z readings.
	logic signed [31:0] y_prod;
	logic signed [31:0] z_prod;
	assign y_prod = accel_y * accel_y;
	assign z_prod = accel_z * accel_z;

	logic [30:0]        ysq_s1;
	logic [30:0]        zsq_s1;
	logic signed [15:0] x_s1;
	tag_t               tag_s1;

	always_ff @(posedge clk) begin
		ysq_s1 <= y_prod[30:0];
		zsq_s1 <= z_prod[30:0];
		x_s1   <= accel_x;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= TAG_IDLE;
		end else begin
			tag_s1 <= '{valid: start && !busy, kind: kind_in};
		end
	end

	// Stage 2: sum of squares.
	logic [31:0]        sum_s2;
	logic signed [15:0] x_s2;
	tag_t               tag_s2;

	always_ff @(posedge clk) begin
		sum_s2 <= {1'b0, ysq_s1} + {1'b0, zsq_s1};
		x_s2   <= x_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= TAG_IDLE;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// Magnitude of the Y-Z vector with 16 fraction bits.
	logic [ROOT_W-1:0]  root;
	logic signed [15:0] x_sq;
	tag_t               tag_sq;

	tac_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.radicand ({sum_s2, 32'd0}),
		.head_x   (x_s2),
		.head_tag (tag_s2),
		.root     (root),
		.tail_x   (x_sq),
		.tail_tag (tag_sq)
	);

	// Angle of (magnitude, x) by vectoring CORDIC.
	logic signed [CX_W-1:0]  vec_x;
	logic signed [CX_W-1:0]  vec_y;
	logic signed [ACC_W-1:0] angle;
	tag_t                    tag_cd;

	assign vec_x = {4'd0, root};
	assign vec_y = {{4{x_sq[15]}}, x_sq, 16'd0};

	tac_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.vec_x    (vec_x),
		.vec_y    (vec_y),
		.head_tag (tag_sq),
		.angle    (angle),
		.tail_tag (tag_cd)
	);

	// Stage F1: split the angle into sign and magnitude.
	logic [30:0] mag_s1f;
	logic        neg_s1f;
	tag_t        tag_s1f;
	logic signed [ACC_W-1:0] angle_abs;

	assign angle_abs = angle[ACC_W-1] ? -angle : angle;

	always_ff @(posedge clk) begin
		mag_s1f <= angle_abs[30:0];
		neg_s1f <= angle[ACC_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1f <= TAG_IDLE;
		end else begin
			tag_s1f <= tag_cd;
		end
	end

	// Stage F2: round to centidegrees, limit, restore the sign; bypass classes take fixed values.
	logic [31:0]              rounded;
	logic [15:0]              whole;
	logic signed [TILT_W-1:0] limited;
	logic signed [TILT_W-1:0] tilt_next;

	assign rounded = {1'b0, mag_s1f} + 32'd32768;
	assign whole   = rounded[31:16];
	assign limited = (whole > 16'(TILT_MAX)) ? TILT_MAX : $signed(whole[TILT_W-1:0]);

	always_comb begin
		case (tag_s1f.kind)
			KIND_NORMAL: tilt_next = neg_s1f ? -limited : limited;
			KIND_ZERO:   tilt_next = '0;
			KIND_POS90:  tilt_next = TILT_MAX;
			KIND_NEG90:  tilt_next = -TILT_MAX;
			default:     tilt_next = '0;
		endcase
	end

	logic signed [TILT_W-1:0] tilt_q;
	logic                     done_q;

	always_ff @(posedge clk) begin
		tilt_q <= tilt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tag_s1f.valid;
		end
	end

	assign done          = done_q;
	assign tilt_centideg = tilt_q;

endmodule

// File: hw/rtl/tac_isqrt.sv
module tac_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [63:0]                 radicand,
	input  logic signed [15:0]          head_x,
	input  tac_pkg::tag_t               head_tag,
	output logic [31:0]                 root,
	output logic signed [15:0]          tail_x,
	output tac_pkg::tag_t               tail_tag
);
	import tac_pkg::*;

	logic [SQ_OP_W-1:0]  op_s  [ISQRT_STEPS];
	logic [SQ_OP_W-1:0]  res_s [ISQRT_STEPS];
	logic signed [15:0]  x_s   [ISQRT_STEPS];
	tag_t                tag_s [ISQRT_STEPS];

	// One restoring square-root step per pipeline stage.
	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
		localparam logic [SQ_OP_W-1:0] BIT = 64'd1 << (SQ_OP_W - 2 - 2 * k);

		logic [SQ_OP_W-1:0] op_prev;
		logic [SQ_OP_W-1:0] res_prev;
		logic signed [15:0] x_prev;
		tag_t               tag_prev;
		logic [SQ_OP_W-1:0] trial;
		logic               take;

		if (k == 0) begin : g_first
			assign op_prev  = radicand;
			assign res_prev = '0;
			assign x_prev   = head_x;
			assign tag_prev = head_tag;
		end else begin : g_next
			assign op_prev  = op_s[k-1];
			assign res_prev = res_s[k-1];
			assign x_prev   = x_s[k-1];
			assign tag_prev = tag_s[k-1];
		end

		assign trial = res_prev + BIT;
		assign take  = (op_prev >= trial);

		// The data path carries no reset; only the tag is cleared.
		always_ff @(posedge clk) begin
			op_s[k]  <= take ? (op_prev - trial) : op_prev;
			res_s[k] <= take ? ((res_prev >> 1) + BIT) : (res_prev >> 1);
			x_s[k]   <= x_prev;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= TAG_IDLE;
			end else begin
				tag_s[k] <= tag_prev;
			end
		end
	end

	assign root     = res_s[ISQRT_STEPS-1][ROOT_W-1:0];
	assign tail_x   = x_s[ISQRT_STEPS-1];
	assign tail_tag = tag_s[ISQRT_STEPS-1];

endmodule

// File: hw/rtl/tac_cordic.sv
module tac_cordic #(
	parameter int unsigned STAGES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic signed [35:0]          vec_x,
	input  logic signed [35:0]          vec_y,
	input  tac_pkg::tag_t               head_tag,
	output logic signed [31:0]          angle,
	output tac_pkg::tag_t               tail_tag
);
	import tac_pkg::*;

	logic signed [CX_W-1:0]  cx_s  [STAGES];
	logic signed [CX_W-1:0]  cy_s  [STAGES];
	logic signed [ACC_W-1:0] acc_s [STAGES];
	tag_t                    tag_s [STAGES];

	// Vectoring CORDIC: each stage rotates the vector toward the x axis.
	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		logic signed [CX_W-1:0]  cx_prev;
		logic signed [CX_W-1:0]  cy_prev;
		logic signed [ACC_W-1:0] acc_prev;
		tag_t                    tag_prev;
		logic signed [CX_W-1:0]  dx;
		logic signed [CX_W-1:0]  dy;
		logic                    up;

		if (i == 0) begin : g_first
			assign cx_prev  = vec_x;
			assign cy_prev  = vec_y;
			assign acc_prev = '0;
			assign tag_prev = head_tag;
		end else begin : g_next
			assign cx_prev  = cx_s[i-1];
			assign cy_prev  = cy_s[i-1];
			assign acc_prev = acc_s[i-1];
			assign tag_prev = tag_s[i-1];
		end

		assign dx = cy_prev >>> i;
		assign dy = cx_prev >>> i;
		assign up = !cy_prev[CX_W-1];

		always_ff @(posedge clk) begin
			if (up) begin
				cx_s[i]  <= cx_prev + dx;
				cy_s[i]  <= cy_prev - dy;
				acc_s[i] <= acc_prev + ATAN_TAB[i];
			end else begin
				cx_s[i]  <= cx_prev - dx;
				cy_s[i]  <= cy_prev + dy;
				acc_s[i] <= acc_prev - ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[i] <= TAG_IDLE;
			end else begin
				tag_s[i] <= tag_prev;
			end
		end
	end

	assign angle    = acc_s[STAGES-1];
	assign tail_tag = tag_s[STAGES-1];

endmodule

// File: hw/rtl/tac_checker.sv
module tac_checker #(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic signed [15:0]  accel_x,
	input logic signed [15:0]  accel_y,
	input logic signed [15:0]  accel_z,
	input logic                done,
	input logic signed [14:0]  tilt_centideg
);
	import tac_pkg::*;

	localparam int unsigned LATENCY = LATENCY_BASE + CORDIC_STAGES;

	// Every accepted request yields its result after the fixed latency.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted request produced no result on time");

	// No result appears without a matching request.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching request");

	// A zero X reading gives exactly zero tilt.
	a_zero_x: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && accel_x == 16'sd0) |-> ##LATENCY
		(done && tilt_centideg == 15'sd0))
		else $error("zero X reading did not give zero tilt");

	// Results stay within plus or minus ninety degrees.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tilt_centideg <= TILT_MAX && tilt_centideg >= -TILT_MAX))
		else $error("tilt result out of range");

endmodule

bind accel_tilt_angle_core tac_checker #(
	.CORDIC_STAGES (CORDIC_STAGES)
) u_tac_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.accel_x       (accel_x),
	.accel_y       (accel_y),
	.accel_z       (accel_z),
	.done          (done),
	.tilt_centideg (tilt_centideg)
);
